FILE: rtl/dsaq_pkg.sv
// dsaq_pkg: shared types, constants and codes of the drift severity alarm qualifier
// used by every module of the block; depends on nothing
`default_nettype none

package dsaq_pkg;

    // fixed constants of the qualifier
    localparam int unsigned PERSIST_LEAK   = 2;
    localparam int unsigned HOLDOFF_FRAMES = 30;
    localparam int unsigned MOM_LIMIT      = 1024;
    localparam int unsigned SCORE_CEIL     = 2560;

    // datapath widths
    localparam int unsigned MAG_W    = 16;
    localparam int unsigned CONF_W   = 9;
    localparam int unsigned GAIN_W   = 12;
    localparam int unsigned LVL_W    = 16;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned MOM_W    = $clog2(MOM_LIMIT + 1);
    localparam int unsigned GM_W     = GAIN_W + MOM_W;
    localparam int unsigned MFAC_W   = GM_W + 1;
    localparam int unsigned P1_W     = MAG_W + CONF_W;
    localparam int unsigned PROD_W   = P1_W + MFAC_W;
    localparam int unsigned SHIFT    = 24;
    localparam int unsigned CONF_ONE = 256;
    localparam int unsigned MFAC_ONE = 65536;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CONF_FLOOR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_FLOOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOM_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVER     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ESCALATE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PERSIST_NEED = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVER_NEED = 3'd7;

    // alert event codes
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_START    = 2'd1;
    localparam logic [1:0] EV_ESCALATE = 2'd2;
    localparam logic [1:0] EV_RESOLVE  = 2'd3;

    typedef struct packed {
        logic [CONF_W-1:0] confidence_floor;
        logic [MAG_W-1:0]  magnitude_floor;
        logic [GAIN_W-1:0] momentum_gain;
        logic [LVL_W-1:0]  trigger_level;
        logic [LVL_W-1:0]  recover_level;
        logic [LVL_W-1:0]  escalate_level;
        logic [CNT_W-1:0]  persist_needed;
        logic [CNT_W-1:0]  recover_needed;
    } dsaq_cfg_t;

    // one classified frame between front and back
    typedef struct packed {
        logic [LVL_W-1:0] severity;
        logic             mom_pos;
    } dsaq_item_t;

endpackage

`default_nettype wire

FILE: rtl/drift_severity_alarm_qualifier.sv
// drift_severity_alarm_qualifier: top level with configuration registers
// instantiates dsaq_front, dsaq_queue and dsaq_back; depends on dsaq_pkg
//
// Usage:
// Frames enter on the in_valid / in_ready channel (drift_magnitude,
// frame_confidence, drift_momentum); one result per frame leaves on the
// out_valid / out_ready channel. A transfer happens when valid and ready are
// both high at a rising edge of clk.
// The front takes a new frame only while idle (in_ready high); its states
// F_MUL1, F_MUL2 and F_SAT then form the severity score, and no new frame is
// taken until the score is handed to the queue. Scored frames wait in a
// two-entry queue; the back updates the persistence, recovery and cooldown
// state as it takes a frame and holds the result in an output register.
// While out_ready is low the result stays put, the queue fills, and then the
// front holds its finished score and drops in_ready.
// Configuration registers are written through cfg_we / cfg_index / cfg_wdata
// with no wait; the user must write them only while the block is idle, which
// the block itself does not enforce; unused data bits are ignored.
// rst_n (asynchronous, active low) empties the pipeline, returns the state
// to nominal with all counters at zero and reloads the register defaults.
`default_nettype none

module drift_severity_alarm_qualifier (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [dsaq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dsaq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [dsaq_pkg::MAG_W-1:0]        drift_magnitude,
    input  wire logic [dsaq_pkg::CONF_W-1:0]       frame_confidence,
    input  wire logic signed [15:0]                drift_momentum,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   alarm_state,
    output logic [1:0]                             alert_event,
    output logic [dsaq_pkg::LVL_W-1:0]             severity_score,
    output logic [dsaq_pkg::CNT_W-1:0]             persist_count,
    output logic [dsaq_pkg::CNT_W-1:0]             recover_count
);
    import dsaq_pkg::*;

    dsaq_cfg_t  cfg_reg;
    logic       push_valid, push_ready, pop_valid, pop_ready;
    dsaq_item_t push_item, pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.confidence_floor <= CONF_W'(128);
            cfg_reg.magnitude_floor  <= MAG_W'(256);
            cfg_reg.momentum_gain    <= GAIN_W'(256);
            cfg_reg.trigger_level    <= LVL_W'(512);
            cfg_reg.recover_level    <= LVL_W'(256);
            cfg_reg.escalate_level   <= LVL_W'(1024);
            cfg_reg.persist_needed   <= CNT_W'(5);
            cfg_reg.recover_needed   <= CNT_W'(10);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CONF_FLOOR:   cfg_reg.confidence_floor <= cfg_wdata[CONF_W-1:0];
                REG_MAG_FLOOR:    cfg_reg.magnitude_floor  <= cfg_wdata[MAG_W-1:0];
                REG_MOM_GAIN:     cfg_reg.momentum_gain    <= cfg_wdata[GAIN_W-1:0];
                REG_TRIGGER:      cfg_reg.trigger_level    <= cfg_wdata[LVL_W-1:0];
                REG_RECOVER:      cfg_reg.recover_level    <= cfg_wdata[LVL_W-1:0];
                REG_ESCALATE:     cfg_reg.escalate_level   <= cfg_wdata[LVL_W-1:0];
                REG_PERSIST_NEED: cfg_reg.persist_needed   <= cfg_wdata[CNT_W-1:0];
                REG_RECOVER_NEED: cfg_reg.recover_needed   <= cfg_wdata[CNT_W-1:0];
            endcase
        end
    end

    dsaq_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .drift_magnitude  (drift_magnitude),
        .frame_confidence (frame_confidence),
        .drift_momentum   (drift_momentum),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_item        (push_item)
    );

    dsaq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    dsaq_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_item        (pop_item),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .alarm_state     (alarm_state),
        .alert_event     (alert_event),
        .severity_score  (severity_score),
        .persist_count   (persist_count),
        .recover_count   (recover_count)
    );

endmodule

`default_nettype wire

FILE: rtl/dsaq_front.sv
// dsaq_front: accepts frames and forms the saturated severity score
// over a short multiply sequence; depends on dsaq_pkg
`default_nettype none

module dsaq_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire dsaq_pkg::dsaq_cfg_t          cfg,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [dsaq_pkg::MAG_W-1:0]   drift_magnitude,
    input  wire logic [dsaq_pkg::CONF_W-1:0]  frame_confidence,
    input  wire logic signed [15:0]           drift_momentum,
    output logic                              push_valid,
    input  wire logic                         push_ready,
    output dsaq_pkg::dsaq_item_t              push_item
);
    import dsaq_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL1 = 2'd1;
    localparam logic [1:0] F_MUL2 = 2'd2;
    localparam logic [1:0] F_SAT  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [MAG_W-1:0]  mag_reg;
    logic [CONF_W-1:0] conf_reg;
    logic [15:0]       mom_reg;
    logic [P1_W-1:0]   p1_reg;
    logic [GM_W-1:0]   gm_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              zero_reg;
    logic              mom_pos_reg;

    logic [MAG_W-1:0]  active;
    logic [CONF_W-1:0] conf_c;
    logic [MOM_W-1:0]  mom_c;
    logic              mom_pos;
    logic              zero;
    logic [MFAC_W-1:0] mfac;
    logic [PROD_W-SHIFT-1:0] prod_hi;

    assign in_ready = (state_reg == F_IDLE);

    always_comb
    begin
        active  = mag_reg - cfg.magnitude_floor;
        conf_c  = (conf_reg > CONF_W'(CONF_ONE)) ? CONF_W'(CONF_ONE) : conf_reg;
        mom_pos = !mom_reg[15] && (mom_reg != 16'd0);
        if (!mom_pos)
            mom_c = '0;
        else if (mom_reg > 16'(MOM_LIMIT))
            mom_c = MOM_W'(MOM_LIMIT);
        else
            mom_c = mom_reg[MOM_W-1:0];
        zero    = (conf_reg < cfg.confidence_floor) || (mag_reg <= cfg.magnitude_floor);
        mfac    = MFAC_W'(MFAC_ONE) + MFAC_W'(gm_reg);
        prod_hi = prod_reg[PROD_W-1:SHIFT];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (in_valid) state_next = F_MUL1;
            F_MUL1: state_next = F_MUL2;
            F_MUL2: state_next = F_SAT;
            F_SAT:  if (push_ready) state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mag_reg  <= drift_magnitude;
            conf_reg <= frame_confidence;
            mom_reg  <= drift_momentum;
        end
        if (state_reg == F_MUL1)
        begin
            p1_reg      <= P1_W'(active) * P1_W'(conf_c);
            gm_reg      <= GM_W'(cfg.momentum_gain) * GM_W'(mom_c);
            zero_reg    <= zero;
            mom_pos_reg <= mom_pos;
        end
        if (state_reg == F_MUL2)
            prod_reg <= PROD_W'(p1_reg) * PROD_W'(mfac);
    end

    assign push_valid         = (state_reg == F_SAT);
    assign push_item.mom_pos  = mom_pos_reg;
    assign push_item.severity = zero_reg ? '0 :
                                (prod_hi > (PROD_W-SHIFT)'(SCORE_CEIL)) ?
                                LVL_W'(SCORE_CEIL) : prod_hi[LVL_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/dsaq_queue.sv
// dsaq_queue: two-entry queue of classified frames between front and back
// depends on dsaq_pkg
`default_nettype none

module dsaq_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push_valid,
    output logic                      push_ready,
    input  wire dsaq_pkg::dsaq_item_t push_item,
    output logic                      pop_valid,
    input  wire logic                 pop_ready,
    output dsaq_pkg::dsaq_item_t      pop_item
);
    import dsaq_pkg::*;

    dsaq_item_t  slot_reg [2];
    logic [1:0]  count_reg, count_next;
    logic        wr_ptr_reg, rd_ptr_reg;
    logic        do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

FILE: rtl/dsaq_back.sv
// dsaq_back: persistence / recovery state machine with cooldown and result register
// depends on dsaq_pkg
`default_nettype none

module dsaq_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire dsaq_pkg::dsaq_cfg_t          cfg,
    input  wire logic                         pop_valid,
    output logic                              pop_ready,
    input  wire dsaq_pkg::dsaq_item_t         pop_item,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              alarm_state,
    output logic [1:0]                        alert_event,
    output logic [dsaq_pkg::LVL_W-1:0]        severity_score,
    output logic [dsaq_pkg::CNT_W-1:0]        persist_count,
    output logic [dsaq_pkg::CNT_W-1:0]        recover_count
);
    import dsaq_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    logic             confirmed_reg, confirmed_next;
    logic [CNT_W-1:0] persist_reg, persist_next;
    logic [CNT_W-1:0] recover_reg, recover_next;
    logic [CNT_W-1:0] cooldown_reg, cooldown_next;
    logic [1:0]       event_next;
    logic             out_valid_reg;
    logic [1:0]       event_reg;
    logic [LVL_W-1:0] severity_reg;
    logic             take;

    assign pop_ready = !out_valid_reg || out_ready;
    assign take      = pop_valid && pop_ready;

    always_comb
    begin
        confirmed_next = confirmed_reg;
        persist_next   = persist_reg;
        recover_next   = recover_reg;
        event_next     = EV_NONE;
        cooldown_next  = (cooldown_reg != '0) ? cooldown_reg - CNT_W'(1) : cooldown_reg;
        if (!confirmed_reg)
        begin
            if (pop_item.severity >= cfg.trigger_level)
            begin
                if (persist_reg != CNT_MAX)
                    persist_next = persist_reg + CNT_W'(1);
                if (persist_next >= cfg.persist_needed)
                begin
                    confirmed_next = 1'b1;
                    recover_next   = '0;
                    if (cooldown_next == '0)
                    begin
                        event_next    = EV_START;
                        cooldown_next = CNT_W'(HOLDOFF_FRAMES);
                    end
                end
            end
            else
            begin
                persist_next = (persist_reg > CNT_W'(PERSIST_LEAK)) ?
                               persist_reg - CNT_W'(PERSIST_LEAK) : '0;
            end
        end
        else
        begin
            if ((pop_item.severity >= cfg.escalate_level) && (cooldown_next == '0))
            begin
                event_next    = EV_ESCALATE;
                cooldown_next = CNT_W'(HOLDOFF_FRAMES);
            end
            if ((pop_item.severity < cfg.recover_level) && !pop_item.mom_pos)
            begin
                if (recover_reg != CNT_MAX)
                    recover_next = recover_reg + CNT_W'(1);
                if (recover_next >= cfg.recover_needed)
                begin
                    confirmed_next = 1'b0;
                    persist_next   = '0;
                    recover_next   = '0;
                    event_next     = EV_RESOLVE;
                    cooldown_next  = CNT_W'(HOLDOFF_FRAMES);
                end
            end
            else
            begin
                recover_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirmed_reg <= 1'b0;
            persist_reg   <= '0;
            recover_reg   <= '0;
            cooldown_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                confirmed_reg <= confirmed_next;
                persist_reg   <= persist_next;
                recover_reg   <= recover_next;
                cooldown_reg  <= cooldown_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            event_reg    <= event_next;
            severity_reg <= pop_item.severity;
        end
    end

    // the state counters double as the result fields
    assign out_valid       = out_valid_reg;
    assign alarm_state     = confirmed_reg;
    assign alert_event     = event_reg;
    assign severity_score  = severity_reg;
    assign persist_count   = persist_reg;
    assign recover_count   = recover_reg;

endmodule

`default_nettype wire

FILE: rtl/dsaq_checker.sv
// dsaq_checker: port-level assertions on the qualifier results, bound to the top level
// depends on dsaq_pkg and drift_severity_alarm_qualifier
`default_nettype none

module dsaq_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic                        alarm_state,
    input wire logic [1:0]                  alert_event,
    input wire logic [dsaq_pkg::LVL_W-1:0]  severity_score,
    input wire logic [dsaq_pkg::CNT_W-1:0]  persist_count,
    input wire logic [dsaq_pkg::CNT_W-1:0]  recover_count
);
    import dsaq_pkg::*;

    // a stalled result holds still
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(alert_event)
            && $stable(severity_score) && $stable(persist_count))
        else $error("result changed while stalled");

    // start and escalation are only reported with the confirmed state set
    a_start_conf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (alert_event == EV_START || alert_event == EV_ESCALATE)
            |-> alarm_state)
        else $error("start or escalation without confirmed state");

    // resolution leaves nominal with both counters cleared
    a_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && alert_event == EV_RESOLVE
            |-> !alarm_state && persist_count == '0 && recover_count == '0)
        else $error("resolution left state behind");

    a_sev_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> severity_score <= LVL_W'(SCORE_CEIL))
        else $error("severity above saturation limit");

    // recovery only counts while confirmed
    a_rec_nominal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !alarm_state |-> recover_count == '0)
        else $error("recovery count while nominal");

endmodule

bind drift_severity_alarm_qualifier dsaq_checker u_dsaq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .alarm_state     (alarm_state),
    .alert_event     (alert_event),
    .severity_score  (severity_score),
    .persist_count   (persist_count),
    .recover_count   (recover_count)
);

`default_nettype wire

FILE: bench/drift_severity_alarm_qualifier_tb.sv
`timescale 1ns / 100ps
// drift_severity_alarm_qualifier_tb: self-checking bench for the drift severity alarm qualifier
// scores and qualifies every frame in a local model and checks each result transfer against it;
// depends on dsaq_pkg and rtl/drift_severity_alarm_qualifier.sv
module drift_severity_alarm_qualifier_tb;
    import dsaq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 115;
    localparam int RUN_CAP     = 60;

    typedef enum {FRAME_HIGH, FRAME_LOW, FRAME_NOISE} frame_kind_t;
    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic             confirmed;
        logic [1:0]       alert;
        logic [LVL_W-1:0] severity;
        logic [CNT_W-1:0] persist;
        logic [CNT_W-1:0] recover;
    } alarm_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [MAG_W-1:0]      drift_magnitude = '0;
    logic [CONF_W-1:0]     frame_confidence = '0;
    logic signed [15:0]    drift_momentum = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  alarm_state;
    logic [1:0]            alert_event;
    logic [LVL_W-1:0]      severity_score;
    logic [CNT_W-1:0]      persist_count;
    logic [CNT_W-1:0]      recover_count;

    // qualifier model: registers and state
    dsaq_cfg_t        q_cfg;
    logic             q_confirmed;
    logic [CNT_W-1:0] q_persist;
    logic [CNT_W-1:0] q_recover;
    logic [CNT_W-1:0] q_cooldown;

    alarm_result_t expected_alarms[$];
    alarm_result_t got_alarm;
    alarm_result_t want_alarm;

    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int phase_left = 0;

    drift_severity_alarm_qualifier DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .drift_magnitude  (drift_magnitude),
        .frame_confidence (frame_confidence),
        .drift_momentum   (drift_momentum),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .alarm_state      (alarm_state),
        .alert_event      (alert_event),
        .severity_score   (severity_score),
        .persist_count    (persist_count),
        .recover_count    (recover_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            flag_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    function automatic logic [LVL_W-1:0] score_of(input logic [MAG_W-1:0] mag,
                                                  input logic [CONF_W-1:0] conf,
                                                  input logic signed [15:0] mom);
        longint unsigned active;
        longint unsigned conf_used;
        longint unsigned mfac;
        longint unsigned prod;
        longint unsigned mom_used;
        if (conf < q_cfg.confidence_floor)
            return '0;
        if (mag <= q_cfg.magnitude_floor)
            return '0;
        active = mag - q_cfg.magnitude_floor;
        conf_used = (conf > CONF_ONE) ? CONF_ONE : conf;
        if (mom <= 0)
            mom_used = 0;
        else if (mom > $signed(MOM_LIMIT))
            mom_used = MOM_LIMIT;
        else
            mom_used = 16'(mom);
        mfac = MFAC_ONE + longint'(q_cfg.momentum_gain) * mom_used;
        prod = (active * conf_used * mfac) >> SHIFT;
        if (prod > SCORE_CEIL)
            prod = SCORE_CEIL;
        return prod[LVL_W-1:0];
    endfunction

    // advances the model state by one frame and returns what the block should report
    function automatic alarm_result_t qualify_frame(input logic [MAG_W-1:0] mag,
                                                    input logic [CONF_W-1:0] conf,
                                                    input logic signed [15:0] mom);
        alarm_result_t r;
        logic [LVL_W-1:0] sev;
        logic [1:0] alert;
        sev = score_of(mag, conf, mom);
        alert = EV_NONE;
        if (q_cooldown != 0)
            q_cooldown--;
        if (!q_confirmed)
        begin
            if (sev >= q_cfg.trigger_level)
            begin
                if (q_persist != 16'hFFFF)
                    q_persist++;
                if (q_persist >= q_cfg.persist_needed)
                begin
                    q_confirmed = 1'b1;
                    q_recover = '0;
                    if (q_cooldown == 0)
                    begin
                        alert = EV_START;
                        q_cooldown = 16'(HOLDOFF_FRAMES);
                    end
                end
            end
            else if (q_persist > PERSIST_LEAK)
                q_persist = q_persist - 16'(PERSIST_LEAK);
            else
                q_persist = '0;
        end
        else
        begin
            if (sev >= q_cfg.escalate_level && q_cooldown == 0)
            begin
                alert = EV_ESCALATE;
                q_cooldown = 16'(HOLDOFF_FRAMES);
            end
            if (sev < q_cfg.recover_level && mom <= 0)
            begin
                if (q_recover != 16'hFFFF)
                    q_recover++;
                if (q_recover >= q_cfg.recover_needed)
                begin
                    // resolution overrides an escalation in the same frame
                    q_confirmed = 1'b0;
                    q_persist = '0;
                    q_recover = '0;
                    alert = EV_RESOLVE;
                    q_cooldown = 16'(HOLDOFF_FRAMES);
                end
            end
            else
                q_recover = '0;
        end
        r.confirmed = q_confirmed;
        r.alert = alert;
        r.severity = sev;
        r.persist = q_persist;
        r.recover = q_recover;
        return r;
    endfunction

    // result side: check each transfer, then pick the next ready level
    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && out_ready)
        begin
            got_alarm = '{alarm_state, alert_event, severity_score, persist_count,
                          recover_count};
            if (expected_alarms.size() == 0)
                flag_error("result transfer with no frame outstanding");
            else
            begin
                want_alarm = expected_alarms.pop_front();
                compare_field("alarm_state", got_alarm.confirmed, want_alarm.confirmed);
                compare_field("alert_event", got_alarm.alert, want_alarm.alert);
                compare_field("severity_score", got_alarm.severity, want_alarm.severity);
                compare_field("persist_count", got_alarm.persist, want_alarm.persist);
                compare_field("recover_count", got_alarm.recover, want_alarm.recover);
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 61; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default:   begin send_idle_pct = 30; recv_stall_pct = 30; end
        endcase
    endtask

    // called at a rising edge; returns at the edge of the input transfer
    task automatic send_frame(input logic [MAG_W-1:0] mag, input logic [CONF_W-1:0] conf,
                              input logic signed [15:0] mom);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        drift_magnitude <= mag;
        frame_confidence <= conf;
        drift_momentum <= mom;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        expected_alarms.push_back(qualify_frame(mag, conf, mom));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_alarms.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // writes all registers back to back; junk goes into the unused upper data bits
    task automatic set_config(input dsaq_cfg_t c);
        write_reg(REG_CONF_FLOOR, {7'($urandom), c.confidence_floor});
        write_reg(REG_MAG_FLOOR, c.magnitude_floor);
        write_reg(REG_MOM_GAIN, {4'($urandom), c.momentum_gain});
        write_reg(REG_TRIGGER, c.trigger_level);
        write_reg(REG_RECOVER, c.recover_level);
        write_reg(REG_ESCALATE, c.escalate_level);
        write_reg(REG_PERSIST_NEED, c.persist_needed);
        write_reg(REG_RECOVER_NEED, c.recover_needed);
        cfg_we <= 1'b0;
        q_cfg = c;
    endtask

    function automatic int unsigned pick(input int unsigned lo, input int unsigned hi,
                                         input int unsigned typ_lo, input int unsigned typ_hi);
        int unsigned r;
        r = $urandom_range(19);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        return $urandom_range(typ_hi, typ_lo);
    endfunction

    function automatic dsaq_cfg_t random_config();
        dsaq_cfg_t c;
        c.confidence_floor = 9'(pick(0, 511, 0, 300));
        c.magnitude_floor  = 16'(pick(0, 65535, 0, 2048));
        c.momentum_gain    = 12'(pick(0, 4095, 0, 4095));
        c.trigger_level    = 16'(pick(0, 65535, 0, 2600));
        c.recover_level    = 16'(pick(0, 65535, 0, 2600));
        c.escalate_level   = 16'(pick(0, 65535, 0, 2600));
        c.persist_needed   = 16'(pick(0, 65535, 1, 8));
        c.recover_needed   = 16'(pick(0, 65535, 1, 12));
        return c;
    endfunction

    function automatic logic [MAG_W-1:0] clamp_mag(input int unsigned v);
        return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    task automatic send_shaped(input frame_kind_t kind);
        logic [MAG_W-1:0]   mag;
        logic [CONF_W-1:0]  conf;
        logic signed [15:0] mom;
        int unsigned        target;
        case (kind)
            FRAME_HIGH:
            begin
                target = $urandom_range(1) ? q_cfg.trigger_level : q_cfg.escalate_level;
                mag = clamp_mag(q_cfg.magnitude_floor + target + $urandom_range(0, 400));
                conf = 9'($urandom_range(511, q_cfg.confidence_floor));
                mom = $urandom_range(1) ? 16'(-$urandom_range(0, 2000))
                                        : 16'($urandom_range(0, 1500));
            end
            FRAME_LOW:
            begin
                mag = clamp_mag(q_cfg.magnitude_floor + $urandom_range(0, q_cfg.recover_level));
                conf = 9'($urandom);
                // now and then a rising momentum breaks the recovery run
                mom = ($urandom_range(9) == 0) ? 16'($urandom_range(1, 32767))
                                               : 16'(-$urandom_range(0, 32768));
            end
            default:
            begin
                mag = 16'($urandom);
                conf = 9'($urandom);
                mom = 16'($urandom);
            end
        endcase
        send_frame(mag, conf, mom);
    endtask

    task automatic send_run(input frame_kind_t kind, input int count);
        if (count > RUN_CAP)
            count = RUN_CAP;
        repeat (count)
        begin
            if (phase_left > 0)
            begin
                send_shaped(kind);
                phase_left--;
            end
        end
    endtask

    task automatic test_reset_defaults();
        set_idle(IDLE_NONE);
        repeat (5)
            send_frame(16'd956, 9'd256, 16'sd0);
        // escalation level reached, but still within cooldown
        send_frame(16'd1756, 9'd300, -16'sd5);
    endtask

    task automatic test_severity_edges();
        wait_idle();
        set_config('{confidence_floor: 9'd0, magnitude_floor: 16'd0, momentum_gain: 12'd4095,
                     trigger_level: 16'd2560, recover_level: 16'd0, escalate_level: 16'd0,
                     persist_needed: 16'd1, recover_needed: 16'hFFFF});
        set_idle(IDLE_BOTH);
        send_frame(16'd0, 9'd0, 16'sd0);
        send_frame(16'hFFFF, 9'h1FF, 16'h7FFF);
        send_frame(16'hFFFF, 9'd256, 16'h8000);
        send_frame(16'd1, 9'd1, 16'sd1024);
        send_frame(16'd1000, 9'd257, 16'sd1025);
        send_frame(16'd40000, 9'd255, 16'sd1);
    endtask

    task automatic test_confidence_floor_high();
        wait_idle();
        set_config('{confidence_floor: 9'd511, magnitude_floor: 16'hFFFF, momentum_gain: 12'd0,
                     trigger_level: 16'd100, recover_level: 16'd50, escalate_level: 16'd900,
                     persist_needed: 16'd2, recover_needed: 16'd2});
        set_idle(IDLE_SEND);
        send_frame(16'hFFFF, 9'h1FF, 16'sd0);
        wait_idle();
        set_config('{confidence_floor: 9'd300, magnitude_floor: 16'd1000, momentum_gain: 12'd0,
                     trigger_level: 16'd100, recover_level: 16'd50, escalate_level: 16'd900,
                     persist_needed: 16'd2, recover_needed: 16'd2});
        send_frame(16'd2000, 9'd299, 16'sd0);
        send_frame(16'd2000, 9'd300, 16'sd0);
        send_frame(16'd2000, 9'h1FF, 16'sd512);
    endtask

    task automatic test_zero_needed();
        wait_idle();
        set_config('{confidence_floor: 9'd0, magnitude_floor: 16'd0, momentum_gain: 12'd256,
                     trigger_level: 16'd0, recover_level: 16'hFFFF, escalate_level: 16'hFFFF,
                     persist_needed: 16'd0, recover_needed: 16'd0});
        set_idle(IDLE_RECV);
        send_frame(16'd0, 9'd0, 16'sd0);
        send_frame(16'd0, 9'd0, -16'sd1);
        send_frame(16'd0, 9'd0, 16'sd5);
        send_frame(16'd100, 9'd256, 16'sd0);
    endtask

    task automatic test_random_sequences();
        dsaq_cfg_t c;
        for (int phase = 0; phase < 10; phase++)
        begin
            wait_idle();
            c = random_config();
            if (phase == 0)
            begin
                c.confidence_floor = '0;
                c.magnitude_floor = '0;
                c.momentum_gain = '0;
                c.trigger_level = '0;
                c.escalate_level = '0;
                c.persist_needed = 16'd1;
                c.recover_needed = 16'd1;
            end
            else if (phase == 1)
            begin
                c.confidence_floor = 9'd256;
                c.momentum_gain = 12'hFFF;
                c.trigger_level = 16'(SCORE_CEIL);
                c.escalate_level = 16'(SCORE_CEIL);
                c.recover_level = 16'hFFFF;
            end
            set_config(c);
            set_idle(idle_mode_t'(phase % 4));
            phase_left = PHASE_ITEMS;
            while (phase_left > 0)
            begin
                case ($urandom_range(9))
                    0, 1: send_run(FRAME_NOISE, 1);
                    2:
                    begin
                        // broken approach: short high run, noise, then a short low run
                        send_run(FRAME_HIGH, $urandom_range(1, 4));
                        send_run(FRAME_NOISE, 1);
                        send_run(FRAME_LOW, $urandom_range(1, 4));
                    end
                    default:
                    begin
                        send_run(FRAME_HIGH, int'(q_cfg.persist_needed) + $urandom_range(0, 45));
                        send_run(FRAME_LOW, int'(q_cfg.recover_needed) + $urandom_range(0, 3));
                    end
                endcase
            end
        end
    endtask

    initial
    begin
        q_cfg = '{confidence_floor: 9'd128, magnitude_floor: 16'd256, momentum_gain: 12'd256,
                  trigger_level: 16'd512, recover_level: 16'd256, escalate_level: 16'd1024,
                  persist_needed: 16'd5, recover_needed: 16'd10};
        q_confirmed = 1'b0;
        q_persist = '0;
        q_recover = '0;
        q_cooldown = '0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_severity_edges();
        test_confidence_floor_high();
        test_zero_needed();
        test_random_sequences();

        wait_idle();
        repeat (20)
            @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
